@@ rtl/core/ssag_pkg.sv @@
// ----------------------------------------------------------------------------
// ssag_pkg: shared types and constants for the spiral scan address generator
// Field widths, configuration register indexes and walk leg codes.
// ----------------------------------------------------------------------------
package ssag_pkg;

  // fixed field widths
  localparam int COORD_W    = 8;
  localparam int DIM_W      = 9;
  localparam int FILL_W     = 32;
  localparam int REMAIN_W   = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // largest matrix side that the coordinate fields can address
  localparam int DIM_CAP = 256;

  // parameter defaults
  localparam int MAX_ROWS_DEF    = 256;
  localparam int MAX_COLS_DEF    = 256;
  localparam int VALUE_WIDTH_DEF = 32;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_ROWS    = 8'd0,
    REG_NUM_COLS    = 8'd1,
    REG_START_VALUE = 8'd2,
    REG_CLOCKWISE   = 8'd3
  } cfg_reg_t;

  // legs of one ring of the clockwise walk frame
  typedef enum logic [1:0] {
    LEG_RIGHT = 2'd0,
    LEG_DOWN  = 2'd1,
    LEG_LEFT  = 2'd2,
    LEG_UP    = 2'd3
  } leg_phase_t;

endpackage

@@ rtl/core/ssag_in_if.sv @@
// ----------------------------------------------------------------------------
// ssag_in_if: input tick channel
// Valid/ready channel carrying the restart flag of one tick.
// ----------------------------------------------------------------------------
interface ssag_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

@@ rtl/core/ssag_out_if.sv @@
// ----------------------------------------------------------------------------
// ssag_out_if: spiral position result channel
// Valid/ready channel carrying one position of the spiral order.
// ----------------------------------------------------------------------------
interface ssag_out_if;
  logic                            valid;
  logic                            ready;
  logic [ssag_pkg::COORD_W-1:0]    row_index;
  logic [ssag_pkg::COORD_W-1:0]    col_index;
  logic signed [ssag_pkg::FILL_W-1:0] fill_value;
  logic                            last_of_pass;
  logic                            overflow;

  modport source (output valid, output row_index, output col_index, output fill_value,
                  output last_of_pass, output overflow, input ready);
  modport sink   (input valid, input row_index, input col_index, input fill_value,
                  input last_of_pass, input overflow, output ready);
endinterface

@@ rtl/core/ssag_cfg_if.sv @@
// ----------------------------------------------------------------------------
// ssag_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface ssag_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ssag_pkg::CFG_IDX_W-1:0]    index;
  logic [ssag_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/spiral_scan_address_generator.sv @@
// ----------------------------------------------------------------------------
// spiral_scan_address_generator: spiral fill order of a rows x cols matrix
// Emits one (row, column, value) position per input tick, clockwise from the
// top row or counterclockwise down the left column, marking the last one.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                          handshake
//  -------  ---  -----------------------------------------------  ---------
//  in_ch    in   restart                                          valid/ready
//  out_ch   out  row_index, col_index, fill_value, last_of_pass,  valid/ready
//                overflow
//  cfg_ch   in   index, data                                      valid/ready
//
//  one tick per clock sustained while out_ch is ready; each result is registered
//  on its transfer in, in a single result register fed by the bound/position logic
//  rst_n (synchronous) restores 1x1 clockwise, start value 0, no pass active
//  a stalled result holds; a new tick is taken in the same cycle the result
//  is taken, so ready follows out_ch.ready when the result register is full
//  cfg_ch is always ready; settings are sampled when a pass begins
//
module spiral_scan_address_generator #(
  parameter int MAX_ROWS    = ssag_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS    = ssag_pkg::MAX_COLS_DEF,
  parameter int VALUE_WIDTH = ssag_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ssag_in_if.sink     in_ch,
  ssag_out_if.source  out_ch,
  ssag_cfg_if.sink    cfg_ch
);

  localparam int CW = ssag_pkg::COORD_W;
  localparam int DW = ssag_pkg::DIM_W;
  localparam int RW = ssag_pkg::REMAIN_W;
  localparam int VW = VALUE_WIDTH;
  localparam int ROW_LIM = (MAX_ROWS < ssag_pkg::DIM_CAP) ? MAX_ROWS : ssag_pkg::DIM_CAP;
  localparam int COL_LIM = (MAX_COLS < ssag_pkg::DIM_CAP) ? MAX_COLS : ssag_pkg::DIM_CAP;
  localparam logic [VW-1:0] MAX_POS = {1'b0, {(VW-1){1'b1}}};

  // configuration registers
  logic [DW-1:0]                    num_rows_r;
  logic [DW-1:0]                    num_cols_r;
  logic [ssag_pkg::CFG_DATA_W-1:0]  start_value_r;
  logic                             clockwise_r;

  // walk state
  logic [CW-1:0]          top_r, bottom_r, left_r, right_r;
  logic [CW-1:0]          cur_row_r, cur_col_r;
  ssag_pkg::leg_phase_t   phase_r;
  logic [VW-1:0]          cur_value_r;
  logic                   overflow_seen_r;
  logic                   pass_active_r;
  logic                   walk_cw_r;
  logic [RW-1:0]          remaining_r;

  logic [CW-1:0]          top_nxt, bottom_nxt, left_nxt, right_nxt;
  logic [CW-1:0]          cur_row_nxt, cur_col_nxt;
  ssag_pkg::leg_phase_t   phase_nxt;
  logic [VW-1:0]          cur_value_nxt;
  logic                   overflow_seen_nxt;
  logic                   pass_active_nxt;
  logic                   walk_cw_nxt;
  logic [RW-1:0]          remaining_nxt;

  // result register
  logic                       out_valid_r;
  logic [CW-1:0]              row_index_r, col_index_r;
  logic [ssag_pkg::FILL_W-1:0] fill_value_r;
  logic                       last_r, overflow_r;

  logic                       in_ready;
  logic                       in_fire;
  logic                       out_fire;
  logic                       pass_start;
  logic [DW-1:0]              rows_cl, cols_cl;
  logic [2*DW-1:0]            area;
  logic [63:0]                start_ext;
  logic signed [63:0]         fill_ext;
  logic                       last_nxt;

  // handshake
  assign in_ready     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = in_ready;
  assign in_fire      = in_ch.valid && in_ready;
  assign out_fire     = out_valid_r && out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign pass_start   = in_ch.restart || !pass_active_r;

  // dimension clamping and pass size
  always_comb begin
    if (num_rows_r == '0) begin
      rows_cl = DW'(1);
    end else if (num_rows_r > DW'(ROW_LIM)) begin
      rows_cl = DW'(ROW_LIM);
    end else begin
      rows_cl = num_rows_r;
    end
    if (num_cols_r == '0) begin
      cols_cl = DW'(1);
    end else if (num_cols_r > DW'(COL_LIM)) begin
      cols_cl = DW'(COL_LIM);
    end else begin
      cols_cl = num_cols_r;
    end
  end

  assign area      = rows_cl * cols_cl;
  assign start_ext = {{32{start_value_r[31]}}, start_value_r};

  // next position in the clockwise walk frame
  always_comb begin
    logic signed [CW+1:0] t, b, l, r, row, col;
    t   = signed'({2'b00, top_r});
    b   = signed'({2'b00, bottom_r});
    l   = signed'({2'b00, left_r});
    r   = signed'({2'b00, right_r});
    row = signed'({2'b00, cur_row_r});
    col = signed'({2'b00, cur_col_r});

    top_nxt           = top_r;
    bottom_nxt        = bottom_r;
    left_nxt          = left_r;
    right_nxt         = right_r;
    cur_row_nxt       = cur_row_r;
    cur_col_nxt       = cur_col_r;
    phase_nxt         = phase_r;
    cur_value_nxt     = cur_value_r;
    overflow_seen_nxt = overflow_seen_r;
    walk_cw_nxt       = walk_cw_r;
    remaining_nxt     = remaining_r;

    if (pass_start) begin
      // new pass: latch settings, counterclockwise walks the transpose
      walk_cw_nxt       = clockwise_r;
      top_nxt           = '0;
      left_nxt          = '0;
      bottom_nxt        = clockwise_r ? CW'(rows_cl - DW'(1)) : CW'(cols_cl - DW'(1));
      right_nxt         = clockwise_r ? CW'(cols_cl - DW'(1)) : CW'(rows_cl - DW'(1));
      cur_row_nxt       = '0;
      cur_col_nxt       = '0;
      phase_nxt         = ssag_pkg::LEG_RIGHT;
      cur_value_nxt     = start_ext[VW-1:0];
      overflow_seen_nxt = 1'b0;
      remaining_nxt     = RW'(area - (2*DW)'(1));
    end else begin
      // running value and sticky wrap flag
      if (cur_value_r == MAX_POS) begin
        overflow_seen_nxt = 1'b1;
      end
      cur_value_nxt = cur_value_r + VW'(1);
      if (remaining_r != '0) begin
        remaining_nxt = remaining_r - RW'(1);
      end

      // step along the current leg, else enter the next non-empty leg
      if (phase_r == ssag_pkg::LEG_RIGHT && col < r) begin
        cur_col_nxt = CW'(col + 1);
      end else if (phase_r == ssag_pkg::LEG_DOWN && row < b) begin
        cur_row_nxt = CW'(row + 1);
      end else if (phase_r == ssag_pkg::LEG_LEFT && col > l) begin
        cur_col_nxt = CW'(col - 1);
      end else if (phase_r == ssag_pkg::LEG_UP && row > t + 1) begin
        cur_row_nxt = CW'(row - 1);
      end else if (phase_r == ssag_pkg::LEG_RIGHT && t + 1 <= b) begin
        phase_nxt   = ssag_pkg::LEG_DOWN;
        cur_row_nxt = CW'(t + 1);
        cur_col_nxt = CW'(r);
      end else if ((phase_r == ssag_pkg::LEG_RIGHT || phase_r == ssag_pkg::LEG_DOWN) &&
                   t < b && r - 1 >= l) begin
        phase_nxt   = ssag_pkg::LEG_LEFT;
        cur_row_nxt = CW'(b);
        cur_col_nxt = CW'(r - 1);
      end else if (phase_r != ssag_pkg::LEG_UP && l < r && b - 1 >= t + 1) begin
        phase_nxt   = ssag_pkg::LEG_UP;
        cur_row_nxt = CW'(b - 1);
        cur_col_nxt = CW'(l);
      end else begin
        // ring done: shrink bounds and start the inner ring
        top_nxt     = CW'(t + 1);
        bottom_nxt  = CW'(b - 1);
        left_nxt    = CW'(l + 1);
        right_nxt   = CW'(r - 1);
        phase_nxt   = ssag_pkg::LEG_RIGHT;
        cur_row_nxt = CW'(t + 1);
        cur_col_nxt = CW'(l + 1);
      end
    end

    last_nxt        = (remaining_nxt == '0);
    pass_active_nxt = !last_nxt;
  end

  // value sign-extended from the value width
  assign fill_ext = 64'(signed'(cur_value_nxt));

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r    <= DW'(1);
      num_cols_r    <= DW'(1);
      start_value_r <= '0;
      clockwise_r   <= 1'b1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        ssag_pkg::REG_NUM_ROWS:    num_rows_r    <= cfg_ch.data[DW-1:0];
        ssag_pkg::REG_NUM_COLS:    num_cols_r    <= cfg_ch.data[DW-1:0];
        ssag_pkg::REG_START_VALUE: start_value_r <= cfg_ch.data;
        ssag_pkg::REG_CLOCKWISE:   clockwise_r   <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // walk state update on each tick transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r           <= '0;
      bottom_r        <= '0;
      left_r          <= '0;
      right_r         <= '0;
      cur_row_r       <= '0;
      cur_col_r       <= '0;
      phase_r         <= ssag_pkg::LEG_RIGHT;
      cur_value_r     <= '0;
      overflow_seen_r <= 1'b0;
      pass_active_r   <= 1'b0;
      walk_cw_r       <= 1'b1;
      remaining_r     <= '0;
    end else if (in_fire) begin
      top_r           <= top_nxt;
      bottom_r        <= bottom_nxt;
      left_r          <= left_nxt;
      right_r         <= right_nxt;
      cur_row_r       <= cur_row_nxt;
      cur_col_r       <= cur_col_nxt;
      phase_r         <= phase_nxt;
      cur_value_r     <= cur_value_nxt;
      overflow_seen_r <= overflow_seen_nxt;
      pass_active_r   <= pass_active_nxt;
      walk_cw_r       <= walk_cw_nxt;
      remaining_r     <= remaining_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      row_index_r  <= walk_cw_nxt ? cur_row_nxt : cur_col_nxt;
      col_index_r  <= walk_cw_nxt ? cur_col_nxt : cur_row_nxt;
      fill_value_r <= fill_ext[ssag_pkg::FILL_W-1:0];
      last_r       <= last_nxt;
      overflow_r   <= overflow_seen_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.row_index    = row_index_r;
  assign out_ch.col_index    = col_index_r;
  assign out_ch.fill_value   = signed'(fill_value_r);
  assign out_ch.last_of_pass = last_r;
  assign out_ch.overflow     = overflow_r;

  // checks
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result register not empty after reset");

  a_pass_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && pass_start) |=> (cur_row_r == '0 && cur_col_r == '0))
    else $error("pass did not begin at origin");

  a_last_ends_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last_nxt) |=> (!pass_active_r && last_r))
    else $error("last position did not close the pass");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !pass_start && overflow_seen_r) |=> (overflow_seen_r && overflow_r))
    else $error("overflow flag dropped within a pass");

  a_take_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ch.ready && in_ch.valid) |-> in_fire)
    else $error("tick refused while result drained");

endmodule

@@ verif/spiral_scan_address_generator_test.sv @@
// ----------------------------------------------------------------------------
// spiral_scan_address_generator_test: self-checking bench for the spiral scan
// Feeds ticks through the input channel, predicts every spiral position from
// its own walk model, and compares each result transfer field by field under
// random idling, a long receiver hold-off and several register settings.
// ----------------------------------------------------------------------------
module spiral_scan_address_generator_test;

  localparam int COORD_W    = ssag_pkg::COORD_W;
  localparam int DIM_W      = ssag_pkg::DIM_W;
  localparam int FILL_W     = ssag_pkg::FILL_W;
  localparam int DIM_CAP    = ssag_pkg::DIM_CAP;
  localparam int CFG_IDX_W  = ssag_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = ssag_pkg::CFG_DATA_W;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_TICKS = 550;
  localparam int HOLD_CYCLES  = 150;
  localparam logic [FILL_W-1:0] FILL_MAX = {1'b0, {(FILL_W-1){1'b1}}};

  typedef struct {
    logic [COORD_W-1:0] row_index;
    logic [COORD_W-1:0] col_index;
    logic [FILL_W-1:0]  fill_value;
    logic               last_of_pass;
    logic               overflow;
  } spiral_pos_t;

  logic clk = 1'b0;
  logic rst_n;

  ssag_in_if  tick_ch();
  ssag_out_if pos_ch();
  ssag_cfg_if cfg_ch();

  spiral_scan_address_generator i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (tick_ch),
    .out_ch (pos_ch),
    .cfg_ch (cfg_ch)
  );

  // register copies, reset values
  logic [DIM_W-1:0]  rows_reg  = 9'd1;
  logic [DIM_W-1:0]  cols_reg  = 9'd1;
  logic [FILL_W-1:0] start_reg = '0;
  logic              cw_reg    = 1'b1;

  // walk state, kept in the clockwise frame
  int          top_edge, bottom_edge, left_edge, right_edge;
  int          walk_row, walk_col;
  ssag_pkg::leg_phase_t walk_leg;
  logic [FILL_W-1:0] walk_value;
  logic        walk_ovf;
  logic        walk_cw;
  logic        pass_live = 1'b0;
  int unsigned positions_left;

  bit          pending_ticks[$];
  spiral_pos_t expected_positions[$];
  bit          tick_taken;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_off_left = 0;
  int          mismatch_count = 0;
  int          idle_cycles = 0;

  always #5 clk = ~clk;

  function automatic int fit_dim(input logic [DIM_W-1:0] dim);
    if (dim == 0) return 1;
    if (dim > DIM_CAP) return DIM_CAP;
    return int'(dim);
  endfunction

  // next spiral position for one accepted tick
  task automatic next_spiral_position(input logic restart_tick, output spiral_pos_t pos);
    int         rows, cols;
    bit         moved, entered;
    ssag_pkg::leg_phase_t turn_leg;
    if (restart_tick || !pass_live) begin
      rows = fit_dim(rows_reg);
      cols = fit_dim(cols_reg);
      walk_cw = cw_reg;
      top_edge = 0;
      left_edge = 0;
      bottom_edge = (walk_cw ? rows : cols) - 1;
      right_edge = (walk_cw ? cols : rows) - 1;
      walk_row = 0;
      walk_col = 0;
      walk_leg = ssag_pkg::LEG_RIGHT;
      walk_value = start_reg;
      walk_ovf = 1'b0;
      positions_left = rows * cols - 1;
      pass_live = 1'b1;
    end else begin
      if (walk_value == FILL_MAX) walk_ovf = 1'b1;
      walk_value = walk_value + 1'b1;
      // step along the current leg
      moved = 1'b1;
      case (walk_leg)
        ssag_pkg::LEG_RIGHT: if (walk_col < right_edge) walk_col++; else moved = 1'b0;
        ssag_pkg::LEG_DOWN:  if (walk_row < bottom_edge) walk_row++; else moved = 1'b0;
        ssag_pkg::LEG_LEFT:  if (walk_col > left_edge) walk_col--; else moved = 1'b0;
        default:             if (walk_row > top_edge + 1) walk_row--; else moved = 1'b0;
      endcase
      // leg ended: enter the next non-empty leg, else shrink the ring
      if (!moved) begin
        entered = 1'b0;
        turn_leg = walk_leg;
        if (turn_leg == ssag_pkg::LEG_RIGHT) begin
          if (top_edge + 1 <= bottom_edge) begin
            walk_leg = ssag_pkg::LEG_DOWN;
            walk_row = top_edge + 1;
            walk_col = right_edge;
            entered = 1'b1;
          end else turn_leg = ssag_pkg::LEG_DOWN;
        end
        if (!entered && turn_leg == ssag_pkg::LEG_DOWN) begin
          if (top_edge < bottom_edge && right_edge - 1 >= left_edge) begin
            walk_leg = ssag_pkg::LEG_LEFT;
            walk_row = bottom_edge;
            walk_col = right_edge - 1;
            entered = 1'b1;
          end else turn_leg = ssag_pkg::LEG_LEFT;
        end
        if (!entered && turn_leg == ssag_pkg::LEG_LEFT) begin
          if (left_edge < right_edge && bottom_edge - 1 >= top_edge + 1) begin
            walk_leg = ssag_pkg::LEG_UP;
            walk_row = bottom_edge - 1;
            walk_col = left_edge;
            entered = 1'b1;
          end
        end
        if (!entered) begin
          top_edge++;
          bottom_edge--;
          left_edge++;
          right_edge--;
          walk_leg = ssag_pkg::LEG_RIGHT;
          walk_row = top_edge;
          walk_col = left_edge;
        end
      end
      if (positions_left > 0) positions_left--;
    end
    pos.last_of_pass = (positions_left == 0);
    if (pos.last_of_pass) pass_live = 1'b0;
    // counterclockwise passes walk the transposed frame
    pos.row_index = COORD_W'(walk_cw ? walk_row : walk_col);
    pos.col_index = COORD_W'(walk_cw ? walk_col : walk_row);
    pos.fill_value = walk_value;
    pos.overflow = walk_ovf;
  endtask

  // predict on tick transfers, check on result transfers
  always @(posedge clk) begin
    spiral_pos_t predicted, want;
    tick_taken = 1'b0;
    if (rst_n) begin
      if (tick_ch.valid && tick_ch.ready) begin
        next_spiral_position(tick_ch.restart, predicted);
        expected_positions.push_back(predicted);
        tick_taken = 1'b1;
      end
      if (pos_ch.valid && pos_ch.ready) begin
        if (expected_positions.size() == 0) begin
          $error("unexpected result: row %0d col %0d", pos_ch.row_index, pos_ch.col_index);
          mismatch_count++;
        end else begin
          want = expected_positions.pop_front();
          if (pos_ch.row_index !== want.row_index) begin
            $error("row_index: expected %0d, got %0d", want.row_index, pos_ch.row_index);
            mismatch_count++;
          end
          if (pos_ch.col_index !== want.col_index) begin
            $error("col_index: expected %0d, got %0d", want.col_index, pos_ch.col_index);
            mismatch_count++;
          end
          if (pos_ch.fill_value !== want.fill_value) begin
            $error("fill_value: expected %0d, got %0d",
                   $signed(want.fill_value), $signed(pos_ch.fill_value));
            mismatch_count++;
          end
          if (pos_ch.last_of_pass !== want.last_of_pass) begin
            $error("last_of_pass: expected %0b, got %0b", want.last_of_pass,
                   pos_ch.last_of_pass);
            mismatch_count++;
          end
          if (pos_ch.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, pos_ch.overflow);
            mismatch_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (tick_ch.valid && tick_ch.ready) || (pos_ch.valid && pos_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // tick driver, fed from the pending queue
  always @(negedge clk) begin
    if (!rst_n) begin
      tick_ch.valid <= 1'b0;
    end else if (!tick_ch.valid || tick_taken) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        tick_ch.valid   <= 1'b1;
        tick_ch.restart <= pending_ticks.pop_front();
      end else begin
        tick_ch.valid   <= 1'b0;
        tick_ch.restart <= 1'($urandom_range(1));
      end
    end
  end

  // result receiver: long hold-off on request, random stalls otherwise
  always @(negedge clk) begin
    if (hold_off_left != 0) begin
      pos_ch.ready <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else begin
      pos_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      ssag_pkg::REG_NUM_ROWS:    rows_reg  = value[DIM_W-1:0];
      ssag_pkg::REG_NUM_COLS:    cols_reg  = value[DIM_W-1:0];
      ssag_pkg::REG_START_VALUE: start_reg = value[FILL_W-1:0];
      ssag_pkg::REG_CLOCKWISE:   cw_reg    = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // one tick with the given restart, then plain advances
  task automatic issue_pass(input int count, input bit lead_restart);
    pending_ticks.push_back(lead_restart);
    for (int i = 1; i < count; i++) pending_ticks.push_back(1'b0);
  endtask

  task automatic wait_idle();
    while (pending_ticks.size() != 0 || tick_ch.valid || expected_positions.size() != 0)
      @(negedge clk);
  endtask

  // stimulus
  initial begin
    int                  seg, random_ticks, n, span, passes;
    bit                  big;
    logic [DIM_W-1:0]    rows_w, cols_w;
    logic [CFG_DATA_W-1:0] cfg_word;
    rst_n          = 1'b0;
    tick_ch.valid  = 1'b0;
    tick_ch.restart = 1'b0;
    pos_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = ssag_pkg::REG_NUM_ROWS;
    cfg_ch.data    = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // 1x1 clockwise defaults: first tick after reset starts a pass without restart
    issue_pass(1, 1'b0);
    issue_pass(1, 1'b1);
    wait_idle();

    // 3x4 clockwise running past the largest value
    write_reg(ssag_pkg::REG_NUM_ROWS, 32'd3);
    write_reg(ssag_pkg::REG_NUM_COLS, 32'd4);
    write_reg(ssag_pkg::REG_START_VALUE, 32'h7FFF_FFFE);
    issue_pass(12, 1'b1);
    wait_idle();

    // zero rows, oversize columns, unused index; restart mid-pass
    write_reg(ssag_pkg::REG_NUM_ROWS, 32'hFFFF_FE00);
    write_reg(ssag_pkg::REG_NUM_COLS, 32'hFFFF_FFFF);
    write_reg(ssag_pkg::REG_START_VALUE, 32'h8000_0000);
    write_reg(CFG_IDX_W'(ssag_pkg::REG_CLOCKWISE + 1), 32'hFFFF_FFFF);
    issue_pass(3, 1'b1);
    issue_pass(2, 1'b1);
    wait_idle();

    // settings written mid-pass wait for the next pass start
    write_reg(ssag_pkg::REG_CLOCKWISE, 32'd0);
    write_reg(ssag_pkg::REG_NUM_ROWS, 32'd2);
    write_reg(ssag_pkg::REG_NUM_COLS, 32'd3);
    issue_pass(1, 1'b0);
    issue_pass(6, 1'b1);
    wait_idle();

    // receiver holds off while a whole pass is offered
    write_reg(ssag_pkg::REG_NUM_ROWS, 32'd4);
    write_reg(ssag_pkg::REG_NUM_COLS, 32'd8);
    write_reg(ssag_pkg::REG_CLOCKWISE, 32'd1);
    hold_off_left = HOLD_CYCLES;
    issue_pass(32, 1'b1);
    wait_idle();
    random_ticks = 32;

    // random segments, each with fresh settings and its own idling
    seg = 0;
    while (random_ticks < RANDOM_TICKS) begin
      case (seg % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      seg++;

      big = ($urandom_range(7) == 0);
      rows_w = big ? DIM_W'($urandom_range(511)) : DIM_W'($urandom_range(1, 8));
      cols_w = big ? DIM_W'($urandom_range(511)) : DIM_W'($urandom_range(1, 8));
      cfg_word = $urandom;
      cfg_word[DIM_W-1:0] = rows_w;
      write_reg(ssag_pkg::REG_NUM_ROWS, cfg_word);
      cfg_word = $urandom;
      cfg_word[DIM_W-1:0] = cols_w;
      write_reg(ssag_pkg::REG_NUM_COLS, cfg_word);
      case ($urandom_range(3))
        0: cfg_word = $urandom;
        1: cfg_word = FILL_MAX - $urandom_range(40);
        2: cfg_word = 32'h8000_0000 + $urandom_range(40);
        default: cfg_word = 32'hFFFF_FFFF - $urandom_range(40);
      endcase
      write_reg(ssag_pkg::REG_START_VALUE, cfg_word);
      write_reg(ssag_pkg::REG_CLOCKWISE, $urandom);
      if ($urandom_range(3) == 0)
        write_reg(CFG_IDX_W'(ssag_pkg::REG_CLOCKWISE + $urandom_range(1, 252)), $urandom);

      span = fit_dim(rows_w) * fit_dim(cols_w);
      n = 0;
      if (big) begin
        // large matrix: the opening part of a pass, now and then restarted
        n = $urandom_range(10, 60);
        for (int i = 0; i < n; i++) pending_ticks.push_back(i == 0 || $urandom_range(15) == 0);
      end else if ($urandom_range(3) != 0) begin
        // whole passes back to back
        passes = $urandom_range(1, 3);
        for (int p = 0; p < passes; p++) begin
          issue_pass(span, (p == 0) ? 1'b1 : 1'($urandom_range(1)));
          n += span;
        end
      end else begin
        // restarts anywhere
        n = $urandom_range(5, 40);
        for (int i = 0; i < n; i++) pending_ticks.push_back($urandom_range(5) == 0);
      end
      random_ticks += n;
      wait_idle();
    end

    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
